### design/gin_pkg.sv
package gin_pkg;

  // Output field widths and limits.
  localparam int IDX_W      = 10;
  localparam int CNT_OUT_W  = 11;
  localparam int IDX_MAX    = 1023;
  localparam int CNT_MAX    = 2047;
  localparam int OUT_FLDS_W = 1 + IDX_W + CNT_OUT_W + 1;
  localparam int OUT_W      = ((OUT_FLDS_W + 7) / 8) * 8;

  // Threshold register, unsigned Q0.16.
  localparam int              THR_W     = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  // Coordinates are used at no more than this many bits so products stay exact.
  localparam int CW_LIMIT = 22;

  // Control part of a box traveling down the chain.
  typedef struct packed {
    logic             vld;     // slot holds a box
    logic             alive;   // examined and not suppressed so far
    logic             stored;  // box has been written into a cell
    logic             over;    // set was full, box not examined
    logic             last;    // last box of its set
    logic [IDX_W-1:0] idx;     // saturated position within the set
  } gin_tok_t;

endpackage

### design/gin_cell.sv
module gin_cell
  import gin_pkg::*;
#(
  parameter int CW    = 16,
  parameter int CNT_W = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [THR_W-1:0]       thr,
  input  gin_tok_t               tok_in,
  input  logic [3:0][CW-1:0]     box_in,
  input  logic signed [2*CW+1:0] area_in,
  input  logic [CNT_W-1:0]       cnt_in,
  output gin_tok_t               tok_out,
  output logic [3:0][CW-1:0]     box_out,
  output logic signed [2*CW+1:0] area_out,
  output logic [CNT_W-1:0]       cnt_out
);

  localparam int DW = CW + 1;
  localparam int AW = 2 * CW + 2;
  localparam int UW = AW + 2;
  localparam int MW = UW + THR_W + 1;

  // Kept box held by this cell.
  logic                valid_r, valid_nxt;
  logic [3:0][CW-1:0]  cb_r;
  logic signed [AW-1:0] ca_r;

  logic signed [CW-1:0] txa, tya, txb, tyb, cxa, cya, cxb, cyb;
  logic signed [CW-1:0] mnx, mxx, mny, mxy;
  logic                 store, disj_nxt, cmp_nxt;
  logic signed [DW-1:0] w_nxt, h_nxt;
  gin_tok_t             s1_tok_nxt;
  logic [CNT_W-1:0]     s1_cnt_nxt;

  // Stage 1: overlap extents.
  gin_tok_t             s1_tok_r;
  logic [3:0][CW-1:0]   s1_box_r;
  logic signed [AW-1:0] s1_area_r, s1_carea_r;
  logic [CNT_W-1:0]     s1_cnt_r;
  logic signed [DW-1:0] s1_w_r, s1_h_r;
  logic                 s1_disj_r, s1_cmp_r;

  // Stage 2: intersection.
  gin_tok_t             s2_tok_r;
  logic [3:0][CW-1:0]   s2_box_r;
  logic signed [AW-1:0] s2_area_r, s2_carea_r, s2_inter_r, s2_inter_nxt;
  logic [CNT_W-1:0]     s2_cnt_r;
  logic                 s2_cmp_r;

  // Stage 3: union and threshold product.
  gin_tok_t             s3_tok_r;
  logic [3:0][CW-1:0]   s3_box_r;
  logic signed [AW-1:0] s3_area_r, s3_inter_r;
  logic [CNT_W-1:0]     s3_cnt_r;
  logic signed [UW-1:0] uni_nxt;
  logic signed [MW-1:0] s3_rhs_r, s3_rhs_nxt;
  logic                 s3_upos_r, s3_uneg_r, s3_cmp_r;

  // Stage 4: decision, which is the cell output.
  gin_tok_t             s4_tok_r, s4_tok_nxt;
  logic [3:0][CW-1:0]   s4_box_r;
  logic signed [AW-1:0] s4_area_r;
  logic [CNT_W-1:0]     s4_cnt_r;
  logic signed [MW-1:0] lhs;
  logic                 sup;

  assign txa = $signed(box_in[0]);
  assign tya = $signed(box_in[1]);
  assign txb = $signed(box_in[2]);
  assign tyb = $signed(box_in[3]);
  assign cxa = $signed(cb_r[0]);
  assign cya = $signed(cb_r[1]);
  assign cxb = $signed(cb_r[2]);
  assign cyb = $signed(cb_r[3]);

  always_comb begin
    mnx = (txb < cxb) ? txb : cxb;
    mxx = (txa > cxa) ? txa : cxa;
    mny = (tyb < cyb) ? tyb : cyb;
    mxy = (tya > cya) ? tya : cya;
    w_nxt = DW'(mnx) - DW'(mxx);
    h_nxt = DW'(mny) - DW'(mxy);
    disj_nxt = (txa > cxb) || (txb < cxa) || (tya > cyb) || (tyb < cya);
    cmp_nxt = tok_in.vld && tok_in.alive && valid_r;
    // A surviving box settles in the first empty cell it reaches. Later boxes
    // trail it by at least one stage, so they always see it here.
    store = tok_in.vld && tok_in.alive && !tok_in.stored && !valid_r;
    s1_tok_nxt = tok_in;
    s1_tok_nxt.stored = tok_in.stored || store;
    s1_cnt_nxt = cnt_in + CNT_W'(valid_r || store);
    valid_nxt = valid_r;
    if (tok_in.vld && tok_in.last) begin
      valid_nxt = 1'b0;
    end else if (store) begin
      valid_nxt = 1'b1;
    end
  end

  always_comb begin
    s2_inter_nxt = s1_disj_r ? '0 : AW'(s1_w_r) * AW'(s1_h_r);
    uni_nxt = UW'(s2_area_r) + UW'(s2_carea_r) - UW'(s2_inter_r);
    s3_rhs_nxt = MW'($signed({1'b0, thr})) * MW'(uni_nxt);
  end

  always_comb begin
    lhs = MW'(s3_inter_r) <<< THR_W;
    if (s3_upos_r) begin
      sup = lhs > s3_rhs_r;
    end else if (s3_uneg_r) begin
      sup = lhs < s3_rhs_r;
    end else begin
      sup = s3_inter_r > 0;
    end
    s4_tok_nxt = s3_tok_r;
    s4_tok_nxt.alive = s3_tok_r.alive && !(s3_cmp_r && sup);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      s1_tok_r <= '0;
      s2_tok_r <= '0;
      s3_tok_r <= '0;
      s4_tok_r <= '0;
    end else if (en) begin
      valid_r  <= valid_nxt;
      s1_tok_r <= s1_tok_nxt;
      s2_tok_r <= s1_tok_r;
      s3_tok_r <= s2_tok_r;
      s4_tok_r <= s4_tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (store) begin
        cb_r <= box_in;
        ca_r <= area_in;
      end
      s1_box_r   <= box_in;
      s1_area_r  <= area_in;
      s1_carea_r <= ca_r;
      s1_cnt_r   <= s1_cnt_nxt;
      s1_w_r     <= w_nxt;
      s1_h_r     <= h_nxt;
      s1_disj_r  <= disj_nxt;
      s1_cmp_r   <= cmp_nxt;

      s2_box_r   <= s1_box_r;
      s2_area_r  <= s1_area_r;
      s2_carea_r <= s1_carea_r;
      s2_cnt_r   <= s1_cnt_r;
      s2_inter_r <= s2_inter_nxt;
      s2_cmp_r   <= s1_cmp_r;

      s3_box_r   <= s2_box_r;
      s3_area_r  <= s2_area_r;
      s3_cnt_r   <= s2_cnt_r;
      s3_inter_r <= s2_inter_r;
      s3_rhs_r   <= s3_rhs_nxt;
      s3_upos_r  <= uni_nxt > 0;
      s3_uneg_r  <= uni_nxt < 0;
      s3_cmp_r   <= s2_cmp_r;

      s4_box_r   <= s3_box_r;
      s4_area_r  <= s3_area_r;
      s4_cnt_r   <= s3_cnt_r;
    end
  end

  assign tok_out  = s4_tok_r;
  assign box_out  = s4_box_r;
  assign area_out = s4_area_r;
  assign cnt_out  = s4_cnt_r;

endmodule

### design/greedy_iou_nms.sv
// Greedy IoU non-maximum suppression over boxes presented in descending score
// order. Each input transaction on in_* carries one box as four signed corner
// coordinates; in_tlast marks the last box of a set and empties the kept store
// once that box has passed. Every input transaction yields exactly one result
// transaction on out_*: keep flag, position in the set, running kept count,
// overflow flag, with out_tlast echoing the set end.
// The user must write the suppression threshold on cfg_* (always ready) only
// while the block is idle; the block does not enforce this. It resets to
// 29491 (about 0.45). A box passes two front-end register stages (corner
// extraction, own area) and then a chain of MAX_BOXES cells, four register
// stages per cell. Each cell holds one kept box and compares it with every
// passing box. While the output is not stalled, boxes follow each other in
// consecutive cycles: throughput is one box per cycle.
// The whole chain advances together; when out_tvalid is high and out_tready low
// the chain holds and in_tready drops in the same cycle, so nothing is lost.
// Reset empties all cells, clears the set position and drops all in-flight
// boxes; it needs no clearing pass.
module greedy_iou_nms
  import gin_pkg::*;
#(
  parameter int MAX_BOXES   = 1024,
  parameter int COORD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // x_min, y_min, x_max, y_max (COORD_WIDTH bits each, lowest first)
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                in_tlast,   // set_end
  output logic                out_tvalid,
  input  logic                out_tready,
  // keep[0], box_index[10:1], kept_count[21:11], overflow[22], zero fill
  output logic [OUT_W-1:0]    out_tdata,
  output logic                out_tlast,  // set_end_out
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THR_W-1:0]    cfg_data    // iou_threshold
);

  localparam int CW    = (COORD_WIDTH > CW_LIMIT) ? CW_LIMIT : COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int AW    = 2 * CW + 2;
  localparam int POS_W = $clog2(MAX_BOXES + 1);
  localparam int CNT_W = POS_W;

  logic              en, acc, over;
  logic [THR_W-1:0]  thr_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [31:0]       pos32, cnt32;
  gin_tok_t          e1_tok_nxt;

  gin_tok_t             e1_tok_r, e2_tok_r;
  logic [3:0][CW-1:0]   e1_box_r, e2_box_r, e1_box_nxt;
  logic signed [DW-1:0] e1_dx_r, e1_dy_r;
  logic signed [AW-1:0] e2_area_r;

  gin_tok_t             tok_c  [MAX_BOXES+1];
  logic [3:0][CW-1:0]   box_c  [MAX_BOXES+1];
  logic signed [AW-1:0] area_c [MAX_BOXES+1];
  logic [CNT_W-1:0]     cnt_c  [MAX_BOXES+1];

  logic [IDX_W-1:0]     out_idx;
  logic [CNT_OUT_W-1:0] out_cnt;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign cfg_ready = 1'b1;

  always_comb begin
    pos32 = 32'(pos_r);
    over  = pos32 >= 32'(MAX_BOXES);
    pos_nxt = pos_r;
    if (acc) begin
      if (in_tlast) begin
        pos_nxt = '0;
      end else if (!over) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
    e1_tok_nxt.vld    = acc;
    e1_tok_nxt.alive  = !over;
    e1_tok_nxt.stored = 1'b0;
    e1_tok_nxt.over   = over;
    e1_tok_nxt.last   = in_tlast;
    e1_tok_nxt.idx    = (pos32 > 32'(IDX_MAX)) ? IDX_W'(IDX_MAX) : pos32[IDX_W-1:0];
    for (int i = 0; i < 4; i++) begin
      e1_box_nxt[i] = in_tdata[i*COORD_WIDTH +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      pos_r    <= '0;
      e1_tok_r <= '0;
      e2_tok_r <= '0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (en) begin
        pos_r    <= pos_nxt;
        e1_tok_r <= e1_tok_nxt;
        e2_tok_r <= e1_tok_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_box_r  <= e1_box_nxt;
      e1_dx_r   <= DW'($signed(e1_box_nxt[2])) - DW'($signed(e1_box_nxt[0]));
      e1_dy_r   <= DW'($signed(e1_box_nxt[3])) - DW'($signed(e1_box_nxt[1]));
      e2_box_r  <= e1_box_r;
      e2_area_r <= AW'(e1_dx_r) * AW'(e1_dy_r);
    end
  end

  assign tok_c[0]  = e2_tok_r;
  assign box_c[0]  = e2_box_r;
  assign area_c[0] = e2_area_r;
  assign cnt_c[0]  = '0;

  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
    gin_cell #(
      .CW    (CW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .thr      (thr_r),
      .tok_in   (tok_c[k]),
      .box_in   (box_c[k]),
      .area_in  (area_c[k]),
      .cnt_in   (cnt_c[k]),
      .tok_out  (tok_c[k+1]),
      .box_out  (box_c[k+1]),
      .area_out (area_c[k+1]),
      .cnt_out  (cnt_c[k+1])
    );
  end

  always_comb begin
    cnt32   = 32'(cnt_c[MAX_BOXES]);
    out_cnt = (cnt32 > 32'(CNT_MAX)) ? CNT_OUT_W'(CNT_MAX) : cnt32[CNT_OUT_W-1:0];
    out_idx = tok_c[MAX_BOXES].idx;
  end

  assign out_tvalid = tok_c[MAX_BOXES].vld;
  assign out_tlast  = tok_c[MAX_BOXES].last;
  assign out_tdata  = OUT_W'({tok_c[MAX_BOXES].over, out_cnt, out_idx,
                              tok_c[MAX_BOXES].stored});

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= 32'(MAX_BOXES))
    else $error("set position beyond capacity");

  a_set_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> pos_r == '0)
    else $error("set position not cleared after set end");

  a_over_not_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tok_c[MAX_BOXES].over |-> !tok_c[MAX_BOXES].stored)
    else $error("overflowed box reported as kept");

  a_kept_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tok_c[MAX_BOXES].stored |-> cnt_c[MAX_BOXES] != '0)
    else $error("kept box with zero kept count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(pos_r) && $stable(e2_tok_r))
    else $error("chain moved while output stalled");
`endif

endmodule
